// ===== hw/rtl/itbs_pkg.sv =====
// Shared constants and the digit-to-ASCII function for the integer-to-base-string block.
package itbs_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned RADIX_W        = 6;
  localparam int unsigned CHAR_W         = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_NINE    = CHAR_W'(8'h39);
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = CHAR_W'(8'h7a);
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = CHAR_W'(8'h2d);
  localparam logic [RADIX_W-1:0] DECIMAL_LIMIT = RADIX_W'(10);

  // Map a digit value to '0'..'9' or 'a'..'z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = CHAR_W'(d);
    if (d < DECIMAL_LIMIT) begin
      return CHAR_ZERO + d_ext;
    end
    return CHAR_LOWER_A + d_ext - CHAR_W'(DECIMAL_LIMIT);
  endfunction

endpackage

// ===== hw/rtl/integer_to_base_string.sv =====
// Top level: signed integer to ASCII text in a configurable base.
//
//   channel  | ports                                 | transfer
//   ---------+---------------------------------------+------------------------------
//   input    | start, busy, in_value                 | start high while busy low
//   result   | out_strobe, out_character, out_last   | every cycle out_strobe is high
//   config   | cfg_we, cfg_wdata                     | every cycle cfg_we is high
//
// Each digit is divided out in the shared bit-serial divider, and each
// character passes through the registered digit RAM read (ST_READ, then
// ST_EMIT); a negative value first sends a '-' from ST_SIGN. Busy stays
// high until the last character is registered. Reset sets the base to ten and
// leaves the block idle.
// The receiver cannot stall: each character is shown for one cycle only.
module integer_to_base_string #(
  parameter int unsigned VALUE_BITS = itbs_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_strobe,
  output logic [itbs_pkg::CHAR_W-1:0]  out_character,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [itbs_pkg::RADIX_W-1:0] cfg_wdata
);
  import itbs_pkg::*;

  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    base_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [CNT_W-1:0]      count_r;
  logic [ADDR_W-1:0]     idx_r;
  logic                  out_strobe_r;
  logic [CHAR_W-1:0]     out_character_r;
  logic                  out_last_r;

  logic [VALUE_BITS-1:0] value_u;
  logic [VALUE_BITS-1:0] mag_in;
  logic [RADIX_W-1:0]    base_eff;
  logic                  accept;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;
  logic                  ram_we;
  logic [RADIX_W-1:0]    ram_rdata;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_wdata;
    end
  end

  // Clamp the base and take the magnitude of the input
  always_comb begin
    if (radix_r < RADIX_MIN) begin
      base_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      base_eff = RADIX_MAX;
    end else begin
      base_eff = radix_r;
    end
    value_u = in_value;
    mag_in  = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
  end

  assign accept = start && (state_r == ST_IDLE);
  assign ram_we = (state_r == ST_DIV_WAIT) && div_done;

  itbs_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_DIV_GO),
    .dividend (mag_r),
    .divisor  (base_r),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  itbs_ram #(
    .WIDTH(RADIX_W),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[ADDR_W-1:0]),
    .wdata(div_rem),
    .re   (state_r == ST_READ),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  // Sequencer: divide out digits, emit any '-', then digits most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      base_r          <= RADIX_RESET;
      mag_r           <= '0;
      neg_r           <= 1'b0;
      count_r         <= '0;
      idx_r           <= '0;
      out_strobe_r    <= 1'b0;
      out_character_r <= '0;
      out_last_r      <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            base_r  <= base_eff;
            mag_r   <= mag_in;
            neg_r   <= value_u[VALUE_BITS-1];
            count_r <= '0;
            state_r <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            count_r <= count_r + 1'b1;
            mag_r   <= div_quot;
            if (div_quot != '0) begin
              state_r <= ST_DIV_GO;
            end else begin
              idx_r   <= count_r[ADDR_W-1:0];
              state_r <= neg_r ? ST_SIGN : ST_READ;
            end
          end
        end
        ST_SIGN: begin
          out_strobe_r    <= 1'b1;
          out_character_r <= CHAR_MINUS;
          out_last_r      <= 1'b0;
          state_r         <= ST_READ;
        end
        ST_READ: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          out_strobe_r    <= 1'b1;
          out_character_r <= digit_char(ram_rdata);
          out_last_r      <= (idx_r == '0);
          if (idx_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            idx_r   <= idx_r - 1'b1;
            state_r <= ST_READ;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

// ===== hw/rtl/itbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module itbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/itbs_divider.sv =====
// Restoring radix-2 divider: one quotient bit per cycle, small divisor.
module itbs_divider #(
  parameter int unsigned VALUE_BITS = itbs_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [VALUE_BITS-1:0]        dividend,
  input  logic [itbs_pkg::RADIX_W-1:0] divisor,
  output logic                         done,
  output logic [VALUE_BITS-1:0]        quotient,
  output logic [itbs_pkg::RADIX_W-1:0] remainder
);
  import itbs_pkg::*;

  localparam int unsigned STEP_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                active_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [VALUE_BITS-1:0] dvd_r;
  logic [RADIX_W-1:0]  rem_r;
  logic [RADIX_W-1:0]  dsr_r;

  logic [RADIX_W:0]    trial;
  logic [RADIX_W:0]    diff;
  logic                fits;
  logic [RADIX_W-1:0]  rem_nxt;

  // Shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    trial   = {rem_r, dvd_r[VALUE_BITS-1]};
    fits    = (trial >= {1'b0, dsr_r});
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        step_r   <= STEP_W'(VALUE_BITS - 1);
      end else if (active_r) begin
        if (step_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
        step_r <= step_r - 1'b1;
      end
    end
  end

  // Dividend turns into the quotient as bits shift through
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (active_r) begin
      dvd_r <= {dvd_r[VALUE_BITS-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// ===== hw/rtl/itbs_checker.sv =====
// Port-level checks for the integer-to-base-string block, bound to the top level.
module itbs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [itbs_pkg::CHAR_W-1:0] out_character,
  input logic                        out_last
);
  import itbs_pkg::*;

  // An accepted transfer keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after accepted input");

  // Every character is '-', a decimal digit or a lower-case letter
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_character == CHAR_MINUS) ||
                    (out_character >= CHAR_ZERO && out_character <= CHAR_NINE) ||
                    (out_character >= CHAR_LOWER_A && out_character <= CHAR_LOWER_Z)))
    else $error("illegal character");

  // A sign never ends the string
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_character == CHAR_MINUS) |-> !out_last)
    else $error("string ends in a sign");

  // The last character is followed by a quiet cycle
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !out_strobe)
    else $error("character right after last");

  // Nothing leaves while the block sat idle in the previous cycle
  a_no_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(!busy) && $past(!start)) |-> !out_strobe)
    else $error("character without a conversion");

endmodule

bind integer_to_base_string itbs_checker u_itbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_character(out_character),
  .out_last     (out_last)
);
